@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the calendar step generator checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define CSG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every rising edge, reset included.
`define CSG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ rtl/core/csg_pkg.sv @@
// ---------------------------------------------------------------------------
// Calendar step generator package
// Field widths, register codes, month tables and leap-year helpers.
// ---------------------------------------------------------------------------
package csg_pkg;

    localparam int HOUR_W     = 5;
    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 14;
    localparam int DOY_W      = 9;
    localparam int INDEX_W    = 24;
    localparam int STEP_W     = 5;
    localparam int TOTAL_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [HOUR_W:0]    HOURS_PER_DAY = 6'd24;
    localparam logic [MONTH_W-1:0] MONTHS        = 4'd12;

    // Divisibility by 25 via the inverse of 25 modulo 2^14.
    localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_YEAR   = 3'd0,
        CFG_START_MONTH  = 3'd1,
        CFG_START_DAY    = 3'd2,
        CFG_START_HOUR   = 3'd3,
        CFG_STEP_HOURS   = 3'd4,
        CFG_RECORD_TOTAL = 3'd5
    } cfg_idx_t;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Days in the months before each month code; invalid high codes count a full year.
    localparam logic [DOY_W-1:0] CUM_DAYS [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
    };

    typedef struct packed {
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [DOY_W-1:0]   doy;
        logic [INDEX_W-1:0] index;
        logic               last;
    } rec_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = (2*YEAR_W)'(y) * (2*YEAR_W)'(INV25);
        div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [MONTH_W-1:0] idx;
        idx = m - 4'd1;
        if (m == 4'd0 || m > MONTHS)
            return 5'd31;
        else if (m == 4'd2 && leap)
            return 5'd29;
        else
            return MONTH_LEN[idx];
    endfunction

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        return CUM_DAYS[m] + ((leap && m >= 4'd3) ? 9'd1 : 9'd0);
    endfunction

endpackage

@@ rtl/core/calendar_step_generator.sv @@
// ---------------------------------------------------------------------------
// Calendar step generator
// Emits one calendar record per input transfer, then advances the calendar.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, payload restart): each transfer
//   yields exactly one record on the output channel (out_valid / out_stall).
//   restart reloads the start date and zeroes the index before the record.
//   Configuration: cfg_write with cfg_index and cfg_data, taken at once;
//   the user must write while the block is idle, unchecked by the block;
//   writes do not touch the running calendar. Throughput: one item per
//   cycle while in_stall is low; the whole step is one pass of logic
//   between the calendar registers, with the leap flag of the current and
//   start years held in registers. Stall: records are registered in an
//   output register plus one skid entry; with both full in_stall rises
//   and holds until the receiver takes a record.
//   Reset: calendar loads 2000-01-01 hour 0, index 0; channels empty.
// ---------------------------------------------------------------------------
module calendar_step_generator #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [csg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [csg_pkg::HOUR_W-1:0]       hour_out,
    output logic [csg_pkg::DAY_W-1:0]        day_out,
    output logic [csg_pkg::MONTH_W-1:0]      month_out,
    output logic [csg_pkg::YEAR_W-1:0]       year_out,
    output logic [csg_pkg::DOY_W-1:0]        day_of_year_out,
    output logic [csg_pkg::INDEX_W-1:0]      record_index,
    output logic                             last_record
);
    import csg_pkg::*;

    localparam int LW = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

    logic [YEAR_W-1:0]      start_year_reg;
    logic [MONTH_W-1:0]     start_month_reg;
    logic [DAY_W-1:0]       start_day_reg;
    logic [HOUR_W-1:0]      start_hour_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   start_leap_reg;

    logic [HOUR_W-1:0]      cur_hour_reg, cur_hour_next;
    logic [DAY_W-1:0]       cur_day_reg, cur_day_next;
    logic [MONTH_W-1:0]     cur_month_reg, cur_month_next;
    logic [YEAR_W-1:0]      cur_year_reg, cur_year_next;
    logic [DOY_W-1:0]       cur_doy_reg, cur_doy_next;
    logic                   cur_leap_reg, cur_leap_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    rec_t                   out_rec_reg, out_rec_next;
    rec_t                   skid_rec_reg;

    logic                   in_accept;
    logic                   out_take;
    rec_t                   rec;
    logic                   src_leap;
    logic [COUNT_WIDTH-1:0] src_count;
    logic [TOTAL_W-1:0]     limit;
    logic [LW-1:0]          limit_w;
    logic [LW-1:0]          count_w;
    logic [LW-1:0]          idx_w;
    logic [HOUR_W:0]        hour_sum;
    logic [DAY_W:0]         day_inc;
    logic [YEAR_W-1:0]      year_inc;

    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;

    // Record for this transfer
    always_comb
    begin
        if (restart)
        begin
            rec.hour  = start_hour_reg;
            rec.day   = start_day_reg;
            rec.month = start_month_reg;
            rec.year  = start_year_reg;
            rec.doy   = DOY_W'(start_day_reg) + days_before(start_month_reg, start_leap_reg);
            src_leap  = start_leap_reg;
            src_count = '0;
        end
        else
        begin
            rec.hour  = cur_hour_reg;
            rec.day   = cur_day_reg;
            rec.month = cur_month_reg;
            rec.year  = cur_year_reg;
            rec.doy   = cur_doy_reg;
            src_leap  = cur_leap_reg;
            src_count = count_reg;
        end

        limit = (total_reg == '0) ? '0 : total_reg - TOTAL_W'(1);
        if (LW'(limit) > LW'({COUNT_WIDTH{1'b1}}))
            limit_w = LW'({COUNT_WIDTH{1'b1}});
        else
            limit_w = LW'(limit);
        count_w   = LW'(src_count);
        rec.last  = (count_w >= limit_w);
        idx_w     = rec.last ? limit_w : count_w;
        rec.index = idx_w[INDEX_W-1:0];
    end

    // Advance the calendar
    always_comb
    begin
        hour_sum       = {1'b0, rec.hour} + (HOUR_W + 1)'(step_reg);
        day_inc        = {1'b0, rec.day} + 6'd1;
        year_inc       = rec.year + 14'd1;
        cur_hour_next  = hour_sum[HOUR_W-1:0];
        cur_day_next   = rec.day;
        cur_month_next = rec.month;
        cur_year_next  = rec.year;
        cur_doy_next   = rec.doy;
        cur_leap_next  = src_leap;
        if (hour_sum >= HOURS_PER_DAY)
        begin
            cur_hour_next = '0;
            cur_day_next  = day_inc[DAY_W-1:0];
            cur_doy_next  = rec.doy + 9'd1;
            if (day_inc > {1'b0, days_in(rec.month, src_leap)})
            begin
                cur_day_next = 5'd1;
                if (rec.month >= MONTHS)
                begin
                    cur_month_next = 4'd1;
                    cur_doy_next   = 9'd1;
                    cur_year_next  = year_inc;
                    cur_leap_next  = is_leap(year_inc);
                end
                else
                begin
                    cur_month_next = rec.month + 4'd1;
                end
            end
        end
        count_next = rec.last ? src_count : src_count + COUNT_WIDTH'(1);
    end

    // Output register and skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_rec_next    = out_rec_reg;
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
                out_rec_next    = skid_rec_reg;
            end
            else
            begin
                out_valid_next = in_accept;
                out_rec_next   = rec;
            end
        end
        else if (in_accept)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_year_reg  <= 14'd2000;
            start_month_reg <= 4'd1;
            start_day_reg   <= 5'd1;
            start_hour_reg  <= 5'd0;
            step_reg        <= 5'd24;
            total_reg       <= 24'd1;
            start_leap_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START_YEAR:
                begin
                    start_year_reg <= cfg_data[YEAR_W-1:0];
                    start_leap_reg <= is_leap(cfg_data[YEAR_W-1:0]);
                end
                CFG_START_MONTH:  start_month_reg <= cfg_data[MONTH_W-1:0];
                CFG_START_DAY:    start_day_reg   <= cfg_data[DAY_W-1:0];
                CFG_START_HOUR:   start_hour_reg  <= cfg_data[HOUR_W-1:0];
                CFG_STEP_HOURS:   step_reg        <= cfg_data[STEP_W-1:0];
                CFG_RECORD_TOTAL: total_reg       <= cfg_data[TOTAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_hour_reg  <= 5'd0;
            cur_day_reg   <= 5'd1;
            cur_month_reg <= 4'd1;
            cur_year_reg  <= 14'd2000;
            cur_doy_reg   <= 9'd1;
            cur_leap_reg  <= 1'b1;
            count_reg     <= '0;
        end
        else if (in_accept)
        begin
            cur_hour_reg  <= cur_hour_next;
            cur_day_reg   <= cur_day_next;
            cur_month_reg <= cur_month_next;
            cur_year_reg  <= cur_year_next;
            cur_doy_reg   <= cur_doy_next;
            cur_leap_reg  <= cur_leap_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rec_reg <= out_rec_next;
        if (in_accept && out_valid_reg && !out_take)
            skid_rec_reg <= rec;
    end

    assign out_valid       = out_valid_reg;
    assign hour_out        = out_rec_reg.hour;
    assign day_out         = out_rec_reg.day;
    assign month_out       = out_rec_reg.month;
    assign year_out        = out_rec_reg.year;
    assign day_of_year_out = out_rec_reg.doy;
    assign record_index    = out_rec_reg.index;
    assign last_record     = out_rec_reg.last;

endmodule

@@ rtl/core/csg_checker.sv @@
// ---------------------------------------------------------------------------
// Calendar step generator checker
// Port-level checks on the channels of the calendar step generator.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module csg_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [csg_pkg::HOUR_W-1:0]       hour_out,
    input logic [csg_pkg::DAY_W-1:0]        day_out,
    input logic [csg_pkg::MONTH_W-1:0]      month_out,
    input logic [csg_pkg::YEAR_W-1:0]       year_out,
    input logic [csg_pkg::DOY_W-1:0]        day_of_year_out,
    input logic [csg_pkg::INDEX_W-1:0]      record_index,
    input logic                             last_record
);
    import csg_pkg::*;

    logic [YEAR_W+MONTH_W+DAY_W+HOUR_W-1:0] date_bits;

    assign date_bits = {year_out, month_out, day_out, hour_out};

    `CSG_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid && !in_stall, "channels not empty in reset")
    `CSG_ASSERT(a_stall_needs_record, clk, rst_n, in_stall |-> out_valid, "input stalled with no record waiting")
    `CSG_ASSERT(a_empty_no_stall, clk, rst_n, !out_valid |=> !in_stall, "input stalled after an empty output")
    `CSG_ASSERT(a_record_held, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(date_bits) && $stable(day_of_year_out) && $stable(record_index) && $stable(last_record), "stalled record changed")

endmodule

bind calendar_step_generator csg_checker u_csg_checker (.*);
